// File: rtl/ifa_pkg.sv
// shared types, codes and constant tables for the integer to ascii formatter
// no dependencies
package ifa_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned CHAR_W  = 8;

  // topmost position index per radix
  localparam logic [POS_W-1:0] HEX_TOP = 5'd7;
  localparam logic [POS_W-1:0] DEC_TOP = 5'd9;
  localparam logic [POS_W-1:0] BIN_TOP = 5'd31;

  localparam logic [DIGIT_W-1:0] DEC_DIGIT_MAX = 4'd9;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = 8'h61;

  typedef enum logic [1:0] {
    CMD_HEX = 2'd0,
    CMD_DEC = 2'd1,
    CMD_BIN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_SHIFT,
    GEN_SUB,
    GEN_DOUT
  } gen_state_t;

  // one digit position handed from the digit generator to the char stage
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               lead;  // leading zero that is not the units position
    logic               pad;   // position lies below the minimum width
    logic [CHAR_W-1:0]  fill;
  } digit_beat_t;

  function automatic logic [VALUE_W-1:0] dec_power(input logic [3:0] pos);
    logic [VALUE_W-1:0] p;
    case (pos)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  // lower case hex letters above nine
  function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_ALPHA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: rtl/ifa_digit_gen.sv
// digit generator: shifts hex and binary digits out of the top of a register,
// builds decimal digits by repeated subtraction of powers of ten
// depends on ifa_pkg
module ifa_digit_gen (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [ifa_pkg::VALUE_W-1:0]  value,
  input  logic [ifa_pkg::WIDTH_W-1:0]  min_width,
  input  logic [ifa_pkg::CHAR_W-1:0]   fill_char,
  output logic                         beat_valid,
  input  logic                         beat_stall,
  output ifa_pkg::digit_beat_t         beat
);
  import ifa_pkg::*;

  gen_state_t           state;
  gen_state_t           state_next;
  logic [VALUE_W-1:0]   val;
  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   power;
  logic [POS_W-1:0]     pos;
  logic [DIGIT_W-1:0]   dcnt;
  logic [WIDTH_W-1:0]   minw;
  logic [CHAR_W-1:0]    fill;
  logic                 is_hex;
  logic                 started;
  logic                 in_take;
  logic                 beat_take;
  logic                 sub_ok;
  logic                 sub_go;
  logic [DIGIT_W-1:0]   digit;
  cmd_t                 cmd;

  assign cmd    = cmd_t'(command);
  assign power  = dec_power(pos[3:0]);
  assign sub_ok = (rem >= power) && (dcnt < DEC_DIGIT_MAX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      GEN_IDLE: begin
        if (in_valid) begin
          case (cmd) inside
            CMD_HEX, CMD_BIN: state_next = GEN_SHIFT;
            CMD_DEC:          state_next = GEN_SUB;
            default:          state_next = GEN_IDLE;
          endcase
        end
      end
      GEN_SHIFT: begin
        if (!beat_stall && pos == '0) state_next = GEN_IDLE;
      end
      GEN_SUB: begin
        if (!sub_ok) state_next = GEN_DOUT;
      end
      GEN_DOUT: begin
        if (!beat_stall) state_next = (pos == '0) ? GEN_IDLE : GEN_SUB;
      end
      default: state_next = GEN_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = (state != GEN_IDLE);
    in_take    = (state == GEN_IDLE) && in_valid;
    beat_valid = (state == GEN_SHIFT) || (state == GEN_DOUT);
    beat_take  = beat_valid && !beat_stall;
    sub_go     = (state == GEN_SUB) && sub_ok;
    if (state == GEN_DOUT) begin
      digit = dcnt;
    end else if (is_hex) begin
      digit = val[VALUE_W-1 -: DIGIT_W];
    end else begin
      digit = {{(DIGIT_W-1){1'b0}}, val[VALUE_W-1]};
    end
    beat.digit = digit;
    beat.pos   = pos;
    beat.lead  = (digit == '0) && !started && (pos != '0);
    beat.pad   = ({1'b0, pos} < minw);
    beat.fill  = fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= GEN_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        started <= 1'b0;
      end else if (beat_take && !beat.lead) begin
        started <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      val    <= value;
      rem    <= value;
      minw   <= min_width;
      fill   <= fill_char;
      dcnt   <= '0;
      is_hex <= (cmd == CMD_HEX);
      case (cmd)
        CMD_HEX: pos <= HEX_TOP;
        CMD_DEC: pos <= DEC_TOP;
        default: pos <= BIN_TOP;
      endcase
    end else if (sub_go) begin
      rem  <= rem - power;
      dcnt <= dcnt + 4'd1;
    end else if (beat_take) begin
      dcnt <= '0;
      if (pos != '0) pos <= pos - 5'd1;
      val <= is_hex ? (val << DIGIT_W) : (val << 1);
    end
  end

endmodule

// File: rtl/ifa_char_out.sv
// char stage: turns digit beats into ascii, drops or pads leading zeros,
// holds the result in an output register
// depends on ifa_pkg
module ifa_char_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        beat_valid,
  output logic                        beat_stall,
  input  ifa_pkg::digit_beat_t        beat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ifa_pkg::CHAR_W-1:0]  character,
  output logic                        last
);
  import ifa_pkg::*;

  logic              beat_take;
  logic              emit;
  logic [CHAR_W-1:0] char_next;

  assign beat_stall = out_valid && out_stall;
  assign beat_take  = beat_valid && !beat_stall;
  // leading zeros at or above the minimum width vanish
  assign emit       = !beat.lead || beat.pad;
  assign char_next  = beat.lead ? beat.fill : ascii_digit(beat.digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!beat_stall) begin
      out_valid <= beat_take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take && emit) begin
      character <= char_next;
      last      <= (beat.pos == '0);
    end
  end

endmodule

// File: rtl/integer_to_ascii_formatter_unit.sv
// integer to ascii formatter, top level
// holds the digit generator and the char output stage; depends on ifa_pkg
//
// converts one unsigned 32-bit value per input beat into ascii text, most
// significant position first, one character per output beat. command picks
// the radix: hex (8 positions, lower case letters), decimal (10 positions)
// or binary (32 positions); command 3 is accepted and produces nothing.
// leading zero positions below min_width come out as fill_char, those at or
// above it are dropped, and the units position always yields a digit with
// last set. one item is in flight at a time: in_stall stays high from the
// accepted beat until the generator has handed over its units digit.
// hex and binary walk one position per cycle, unless the char stage stalls,
// out of a left shifting value register. decimal shares one 32-bit compare
// and subtract unit across its 10 positions: each position subtracts its
// power of ten once per unit of its digit, then hands the digit over. while
// a character waits in the output register, the generator stalls any beat
// it offers; decimal subtraction goes on meanwhile.
module integer_to_ascii_formatter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [ifa_pkg::VALUE_W-1:0] value,
  input  logic [ifa_pkg::WIDTH_W-1:0] min_width,
  input  logic [ifa_pkg::CHAR_W-1:0]  fill_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ifa_pkg::CHAR_W-1:0]  character,
  output logic                        last
);
  import ifa_pkg::*;

  // per-position beats between generator and char stage
  logic        beat_valid;
  logic        beat_stall;
  digit_beat_t beat;

  ifa_digit_gen u_digit_gen (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .value      (value),
    .min_width  (min_width),
    .fill_char  (fill_char),
    .beat_valid (beat_valid),
    .beat_stall (beat_stall),
    .beat       (beat)
  );

  ifa_char_out u_char_out (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat_stall (beat_stall),
    .beat       (beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last)
  );

endmodule

// File: sim/formatter_text_checker.sv
// beat monitor and text predictor for the integer to ascii formatter
// depends on ifa_pkg; instantiated next to the block by the testbench top
`timescale 1ns / 1ps

module formatter_text_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [ifa_pkg::VALUE_W-1:0] value,
  input  logic [ifa_pkg::WIDTH_W-1:0] min_width,
  input  logic [ifa_pkg::CHAR_W-1:0]  fill_char,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ifa_pkg::CHAR_W-1:0]  character,
  input  logic                        last,
  output int                          failures,
  output int                          pending
);
  import ifa_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
  } text_beat_t;

  text_beat_t expected_text[$];

  // append the characters one number turns into
  task automatic predict_text(input logic [1:0] radix, input logic [VALUE_W-1:0] num,
                              input logic [WIDTH_W-1:0] minw, input logic [CHAR_W-1:0] fill);
    int                i;
    int unsigned       npos;
    int unsigned       width;
    int unsigned       rem;
    int unsigned       scale;
    logic [DIGIT_W-1:0] d;
    logic [CHAR_W-1:0] ch;
    bit                started;
    case (radix)
      CMD_HEX: npos = int'(HEX_TOP) + 1;
      CMD_DEC: npos = int'(DEC_TOP) + 1;
      CMD_BIN: npos = int'(BIN_TOP) + 1;
      default: npos = 0;
    endcase
    width   = (minw > npos) ? npos : minw;
    rem     = num;
    started = 1'b0;
    for (i = int'(npos) - 1; i >= 0; i--) begin
      d = '0;
      if (radix == CMD_HEX) begin
        d = num[i*4 +: 4];
      end else if (radix == CMD_BIN) begin
        d = {3'b000, num[i]};
      end else begin
        scale = 1;
        repeat (i) scale = scale * 10;
        while (rem >= scale && d < DEC_DIGIT_MAX) begin
          rem = rem - scale;
          d   = d + 4'd1;
        end
      end
      if (d == '0 && !started && i > 0) begin
        if (i < int'(width)) expected_text.push_back({fill, 1'b0});
      end else begin
        if (d < 4'd10) ch = CHAR_ZERO + {4'd0, d};
        else ch = CHAR_ALPHA + {4'd0, d} - 8'd10;
        expected_text.push_back({ch, i == 0});
        started = 1'b1;
      end
    end
  endtask

  initial begin
    failures = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst) begin
      if (in_valid && !in_stall) predict_text(command, value, min_width, fill_char);
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $error("unexpected beat: character %02h last %0b", character, last);
          failures++;
        end else begin
          want = expected_text.pop_front();
          if (character !== want.ch) begin
            $error("character: expected %02h, got %02h", want.ch, character);
            failures++;
          end
          if (last !== want.lst) begin
            $error("last: expected %0b, got %0b", want.lst, last);
            failures++;
          end
        end
      end
    end
    pending <= expected_text.size();
  end

endmodule

// File: sim/integer_to_ascii_formatter_unit_tb.sv
// testbench top for the integer to ascii formatter: clock, reset, stimulus, verdict
// depends on ifa_pkg, the block and formatter_text_checker
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_tb;
  import ifa_pkg::*;

  // slowest legal run is roughly 310 binary items, every char stalled its longest
  localparam int LIMIT_CYCLES = 1000000;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES  = 400;
  // the slowest item is decimal, the quickest a command 3 item
  localparam int DRAIN_CYCLES = 200;

  localparam logic [1:0]        CMD_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] FILL_SPACE = 8'h20;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic [VALUE_W-1:0] value;
  logic [WIDTH_W-1:0] min_width;
  logic [CHAR_W-1:0]  fill_char;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  character;
  logic               last;

  int failures;
  int pending;
  int cycle_count = 0;

  // knobs that steer the sender and the receiver
  bit tx_gaps     = 1'b1;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;

  always #10 clk = ~clk;

  integer_to_ascii_formatter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .min_width (min_width),
    .fill_char (fill_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  formatter_text_checker text_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .min_width (min_width),
    .fill_char (fill_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last),
    .failures  (failures),
    .pending   (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request, none at the end
  // each pass drives out_stall once and then waits on the clock
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // offer one number and hold it until taken, then maybe go idle a while
  task automatic send_number(input logic [1:0] cmd, input logic [VALUE_W-1:0] num,
                             input logic [WIDTH_W-1:0] minw, input logic [CHAR_W-1:0] fill);
    command   <= cmd;
    value     <= num;
    min_width <= minw;
    fill_char <= fill;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // mix of full-range, small, single-bit, shifted-down and below-100000 values
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return $urandom_range(0, 255);
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom() >> $urandom_range(0, 31);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  task automatic send_random_number();
    logic [1:0]         cmd;
    logic [WIDTH_W-1:0] minw;
    logic [CHAR_W-1:0]  fill;
    // unused radix now and then
    cmd = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    // mostly widths around the digit counts, sometimes the whole field range
    minw = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 33));
    case ($urandom_range(0, 3))
      0:       fill = FILL_SPACE;
      1:       fill = CHAR_ZERO;
      default: fill = 8'($urandom_range(0, 255));
    endcase
    send_number(cmd, pick_value(), minw, fill);
  endtask

  // sender goes quiet until every predicted character has come out
  task automatic wait_for_text();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= CMD_HEX;
    value     <= '0;
    min_width <= '0;
    fill_char <= FILL_SPACE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: hex edges, zero with and without padding, oversized widths
    send_number(CMD_HEX, 32'h0000_0000, 6'd0,  FILL_SPACE);
    send_number(CMD_HEX, 32'h0000_0000, 6'd8,  CHAR_ZERO);
    send_number(CMD_HEX, 32'hffff_ffff, 6'd0,  FILL_SPACE);
    send_number(CMD_HEX, 32'hdead_beef, 6'd32, 8'h00);
    send_number(CMD_HEX, 32'h0000_001a, 6'd63, 8'hff);
    send_number(CMD_HEX, 32'h0abc_0000, 6'd5,  CHAR_ZERO);
    // decimal: zero, largest value, lone power of ten, nines, padding
    send_number(CMD_DEC, 32'd0,          6'd1,  FILL_SPACE);
    send_number(CMD_DEC, 32'd0,          6'd10, CHAR_ZERO);
    send_number(CMD_DEC, 32'hffff_ffff,  6'd0,  FILL_SPACE);
    send_number(CMD_DEC, 32'd1000000000, 6'd12, CHAR_ZERO);
    send_number(CMD_DEC, 32'd9,          6'd3,  FILL_SPACE);
    send_number(CMD_DEC, 32'd999999999,  6'd11, 8'h2a);
    send_number(CMD_DEC, 32'd1234567890, 6'd63, 8'hff);
    // binary: zero fully padded, single bits at both ends, all ones
    send_number(CMD_BIN, 32'h0000_0000, 6'd32, CHAR_ZERO);
    send_number(CMD_BIN, 32'h0000_0001, 6'd0,  FILL_SPACE);
    send_number(CMD_BIN, 32'h8000_0000, 6'd0,  FILL_SPACE);
    send_number(CMD_BIN, 32'hffff_ffff, 6'd40, 8'h00);
    send_number(CMD_BIN, 32'h0000_0005, 6'd33, 8'h5f);
    // unused radix yields no characters
    send_number(CMD_UNUSED, 32'hffff_ffff, 6'd63, 8'hff);
    send_number(CMD_UNUSED, 32'h0000_0000, 6'd0,  8'h00);
    send_number(CMD_HEX, 32'h0000_0010, 6'd1,  FILL_SPACE);

    repeat (130) send_random_number();

    // drain fully before the hold-off
    wait_for_text();

    // receiver holds off while the sender keeps pushing back to back
    tx_gaps     = 1'b0;
    rx_hold_req = 1'b1;
    repeat (8) send_random_number();
    tx_gaps = 1'b1;

    repeat (110) send_random_number();

    // closing stretch runs at full rate on both sides
    rx_quiet = 1'b1;
    tx_gaps  = 1'b0;
    repeat (45) send_random_number();

    wait_for_text();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
